>>> hw/rtl/mdhw_pkg.sv
package mdhw_pkg;

  localparam int DEVICES   = 8;
  localparam int DEV_IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int CNT_W     = $clog2(DEVICES + 1);
  localparam int MASK_W    = 8;

  localparam int TIME_W       = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int TIMEOUT_W    = 16;
  localparam int SPECIAL_W    = 3;
  localparam int MARGIN_W     = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [SPECIAL_W-1:0] SPECIAL_RST = 3'd0;
  localparam logic [MARGIN_W-1:0]  MARGIN_RST  = 16'd500;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 2'd2;

  localparam logic CMD_ALIVE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [2:0]        device_index;
    logic [TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] connected_mask;
    logic [3:0]        connected_count;
    logic              crutch_lost;
    logic              all_lost;
    logic [MASK_W-1:0] future_mask;
    logic              no_device_seen;
  } out_item_t;

  // Result of checking one stored stamp against the current time.
  typedef struct packed {
    logic expired;
    logic future;
  } cmp_res_t;

endpackage

>>> hw/rtl/multi_device_heartbeat_watchdog.sv
// Heartbeat watchdog for up to DEVICES devices. An alive transaction stores the
// device's stamp. A tick transaction walks the device table one entry per cycle
// through a single add-and-compare unit and then writes its result; a tick
// before any heartbeat answers with no_device_seen without a walk. The result
// sits in an output register; the next transaction is taken once that register
// is empty or being drained.
// Configuration writes go straight into their registers.
module multi_device_heartbeat_watchdog (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mdhw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mdhw_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [mdhw_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mdhw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mdhw_pkg::*;

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t                state_r, state_nxt;
  logic [TIMEOUT_W-1:0]  timeout_r;
  logic [SPECIAL_W-1:0]  special_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic [TIME_W-1:0]     stamp_r [DEVICES];
  logic [DEVICES-1:0]    seen_r, seen_nxt;
  logic [DEVICES-1:0]    conn_r, conn_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [DEV_IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]      remain_r, remain_nxt;
  logic                  had_r, had_nxt;
  logic                  crutch_r, crutch_nxt;
  logic [MASK_W-1:0]     future_r, future_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic                  in_fire;
  logic                  stamp_we;
  cmp_res_t              cmp;
  logic [CNT_W-1:0]      conn_cnt;
  logic [CNT_W-1:0]      remain_dec;
  logic                  idx_last;
  logic [MASK_W-1:0]     conn_mask;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign stamp_we  = in_fire && (in_data.cmd == CMD_ALIVE) &&
                     (32'(in_data.device_index) < DEVICES);
  assign idx_last  = (32'(idx_r) == DEVICES - 1);
  assign remain_dec = remain_r - CNT_W'(1);

  mdhw_cmp_unit u_cmp (
    .stamp            (stamp_r[idx_r]),
    .now              (now_r),
    .timeout_ms       (timeout_r),
    .future_margin_ms (margin_r),
    .res              (cmp)
  );

  always_comb begin
    conn_cnt = '0;
    for (int k = 0; k < DEVICES; k++) begin
      conn_cnt = conn_cnt + CNT_W'(conn_r[k]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    conn_nxt      = conn_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    remain_nxt    = remain_r;
    had_nxt       = had_r;
    crutch_nxt    = crutch_r;
    future_nxt    = future_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    conn_mask     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_ALIVE) begin
            if (stamp_we) begin
              seen_nxt[DEV_IDX_W'(in_data.device_index)] = 1'b1;
            end
          end else if (seen_r == '0) begin
            out_nxt                = '0;
            out_nxt.no_device_seen = 1'b1;
            out_valid_nxt          = 1'b1;
          end else begin
            now_nxt    = in_data.time_value;
            idx_nxt    = '0;
            remain_nxt = conn_cnt;
            had_nxt    = (conn_cnt != '0);
            crutch_nxt = 1'b0;
            future_nxt = '0;
            state_nxt  = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (seen_r[idx_r]) begin
          if (conn_r[idx_r] && cmp.expired) begin
            conn_nxt[idx_r] = 1'b0;
            remain_nxt      = remain_dec;
            if ((32'(idx_r) == 32'(special_r)) && (remain_dec != '0)) begin
              crutch_nxt = 1'b1;
            end
          end else if (!conn_r[idx_r] && !cmp.expired) begin
            conn_nxt[idx_r] = 1'b1;
            remain_nxt      = remain_r + CNT_W'(1);
          end
          for (int k = 0; k < MASK_W; k++) begin
            if (cmp.future && (32'(idx_r) == k)) begin
              future_nxt[k] = 1'b1;
            end
          end
        end
        if (idx_last) begin
          for (int k = 0; k < MASK_W; k++) begin
            if (k < DEVICES) begin
              conn_mask[k] = conn_nxt[k % DEVICES];
            end
          end
          out_nxt.connected_mask  = conn_mask;
          out_nxt.connected_count = 4'(remain_nxt);
          out_nxt.crutch_lost     = crutch_nxt;
          out_nxt.all_lost        = had_r && (remain_nxt == '0);
          out_nxt.future_mask     = future_nxt;
          out_nxt.no_device_seen  = 1'b0;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          idx_nxt = idx_r + DEV_IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RST;
      special_r   <= SPECIAL_RST;
      margin_r    <= MARGIN_RST;
      seen_r      <= '0;
      conn_r      <= '0;
      idx_r       <= '0;
      remain_r    <= '0;
      had_r       <= 1'b0;
      crutch_r    <= 1'b0;
      future_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      conn_r      <= conn_nxt;
      idx_r       <= idx_nxt;
      remain_r    <= remain_nxt;
      had_r       <= had_nxt;
      crutch_r    <= crutch_nxt;
      future_r    <= future_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_TIMEOUT: timeout_r <= TIMEOUT_W'(cfg_wdata);
          REG_SPECIAL: special_r <= SPECIAL_W'(cfg_wdata);
          REG_MARGIN:  margin_r  <= MARGIN_W'(cfg_wdata);
          default: begin
            // drop writes to unused indexes
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    out_r <= out_nxt;
    if (stamp_we) begin
      stamp_r[DEV_IDX_W'(in_data.device_index)] <= in_data.time_value;
    end
  end

endmodule

>>> hw/rtl/mdhw_cmp_unit.sv
module mdhw_cmp_unit (
  input  logic [mdhw_pkg::TIME_W-1:0]    stamp,
  input  logic [mdhw_pkg::TIME_W-1:0]    now,
  input  logic [mdhw_pkg::TIMEOUT_W-1:0] timeout_ms,
  input  logic [mdhw_pkg::MARGIN_W-1:0]  future_margin_ms,
  output mdhw_pkg::cmp_res_t             res
);
  import mdhw_pkg::*;

  logic [TIME_W:0] deadline;
  logic [TIME_W:0] horizon;

  // 33-bit sums never wrap
  assign deadline = {1'b0, stamp} + (TIME_W + 1)'(timeout_ms);
  assign horizon  = {1'b0, now} + (TIME_W + 1)'(future_margin_ms);

  assign res.expired = {1'b0, now} > deadline;
  assign res.future  = horizon < {1'b0, stamp};

endmodule

>>> bench/watchdog_checker.sv
`timescale 1ns / 100ps

module watchdog_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  mdhw_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  mdhw_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [mdhw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mdhw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     pending,
  output int unsigned                     errors,
  output int unsigned                     checked
);
  import mdhw_pkg::*;

  // Shadow copy of the device table and the registers.
  logic [TIME_W-1:0]    stamp_tbl [DEVICES];
  logic [DEVICES-1:0]   seen;
  logic [DEVICES-1:0]   linked;
  logic [TIMEOUT_W-1:0] limit_ms;
  logic [SPECIAL_W-1:0] crutch_dev;
  logic [MARGIN_W-1:0]  lead_ms;

  out_item_t status_q [$];

  initial begin
    errors  = 0;
    checked = 0;
    pending = 0;
  end

  // Update the shadow table for one transaction; return 1 with the status
  // word when the transaction is a tick.
  function automatic bit apply_item(input in_item_t it, output out_item_t st);
    logic [TIME_W:0] now_w;
    logic [TIME_W:0] stamp_w;
    bit              expired;
    int              remaining;
    bit              had;
    st = '0;
    if (it.cmd == CMD_ALIVE) begin
      if (it.device_index < DEVICES) begin
        stamp_tbl[it.device_index] = it.time_value;
        seen[it.device_index] = 1'b1;
      end
      return 1'b0;
    end
    if (seen == '0) begin
      st.no_device_seen = 1'b1;
      return 1'b1;
    end
    remaining = $countones(linked);
    had = (remaining != 0);
    now_w = {1'b0, it.time_value};
    for (int i = 0; i < DEVICES; i++) begin
      if (!seen[i]) continue;
      stamp_w = {1'b0, stamp_tbl[i]};
      expired = (now_w > stamp_w + limit_ms);
      if (linked[i] && expired) begin
        linked[i] = 1'b0;
        remaining--;
        if (i == crutch_dev && remaining != 0) st.crutch_lost = 1'b1;
      end else if (!linked[i] && !expired) begin
        linked[i] = 1'b1;
        remaining++;
      end
      if (i < MASK_W && now_w + lead_ms < stamp_w) st.future_mask[i] = 1'b1;
    end
    for (int i = 0; i < DEVICES && i < MASK_W; i++)
      st.connected_mask[i] = linked[i];
    st.connected_count = remaining[3:0];
    st.all_lost = had && (remaining == 0);
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      seen       = '0;
      linked     = '0;
      limit_ms   = TIMEOUT_RST;
      crutch_dev = SPECIAL_RST;
      lead_ms    = MARGIN_RST;
      status_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TIMEOUT: limit_ms   = cfg_wdata[TIMEOUT_W-1:0];
          REG_SPECIAL: crutch_dev = cfg_wdata[SPECIAL_W-1:0];
          REG_MARGIN:  lead_ms    = cfg_wdata[MARGIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("status transaction with no tick waiting: 0x%0h", out_data);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("connected_mask", want.connected_mask, out_data.connected_mask);
          check_field("connected_count", want.connected_count, out_data.connected_count);
          check_field("crutch_lost", want.crutch_lost, out_data.crutch_lost);
          check_field("all_lost", want.all_lost, out_data.all_lost);
          check_field("future_mask", want.future_mask, out_data.future_mask);
          check_field("no_device_seen", want.no_device_seen, out_data.no_device_seen);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (apply_item(in_data, fresh)) status_q.push_back(fresh);
      end
      pending <= status_q.size();
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import mdhw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 250;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned pending_results;
  int unsigned mismatches;
  int unsigned results_checked;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned cur_timeout = 32'(TIMEOUT_RST);
  int unsigned cur_margin  = 32'(MARGIN_RST);
  longint      now_ms;

  multi_device_heartbeat_watchdog dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  watchdog_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pending   (pending_results),
    .errors    (mismatches),
    .checked   (results_checked)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #7_200_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [TIME_W-1:0] clamp32(input longint v);
    if (v < 0) return '0;
    if (v > 64'hFFFF_FFFF) return '1;
    return v[TIME_W-1:0];
  endfunction

  // Offer one transaction; valid stays high across back-to-back items.
  task automatic offer(input logic c, input logic [2:0] dev, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: c, device_index: dev, time_value: t};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, wait for every status to drain, then let the block go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned t, input int unsigned s,
                              input int unsigned m);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_idx   <= REG_TIMEOUT;
    cfg_wdata <= t[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_idx   <= REG_SPECIAL;
    cfg_wdata <= {13'($urandom), 3'(s)};
    @(posedge clk);
    cfg_idx   <= REG_MARGIN;
    cfg_wdata <= m[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_timeout = t;
    cur_margin  = m;
  endtask

  // A few heartbeats around the current time, then a tick at that time.
  task automatic run_round();
    int     n;
    longint stamp;
    now_ms += $urandom_range(cur_timeout * 2 + 2);
    if ($urandom_range(19) == 0) now_ms += $urandom_range(200_000);
    // wrap back to small times so old stamps appear to lie in the future
    if (now_ms > 64'hFFFF_FFFF) now_ms = $urandom_range(3000);
    n = $urandom_range(4);
    repeat (n) begin
      case ($urandom_range(9))
        0: stamp = now_ms - cur_timeout - 1 - $urandom_range(50);
        1: stamp = now_ms - cur_timeout;
        2: stamp = now_ms + cur_margin + 1 + $urandom_range(50);
        3: stamp = now_ms + cur_margin;
        default: stamp = now_ms - $urandom_range(cur_timeout);
      endcase
      offer(CMD_ALIVE, 3'($urandom), clamp32(stamp));
    end
    offer(CMD_TICK, 3'($urandom), clamp32(now_ms));
  endtask

  task automatic run_phase(input int unsigned t, input int unsigned s, input int unsigned m,
                           input int unsigned idle, input int unsigned stall,
                           input bit hold, input int unsigned count);
    int unsigned stop_at;
    program_regs(t, s, m);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (hold) hold_req <= hold_req + 1;
    now_ms = $urandom;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) run_round();
      else offer(1'($urandom), 3'($urandom), $urandom);
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, timeout 1000, crutch 0, margin 500.
    offer(CMD_TICK,  3'd5, 32'd0);
    offer(CMD_TICK,  3'd2, 32'hFFFF_FFFF);
    offer(CMD_ALIVE, 3'd0, 32'd5000);
    offer(CMD_ALIVE, 3'd1, 32'd5000);
    offer(CMD_ALIVE, 3'd2, 32'd5000);
    offer(CMD_TICK,  3'd7, 32'd6000);       // exactly at the timeout edge
    offer(CMD_TICK,  3'd0, 32'd6001);       // crutch first, then everyone
    offer(CMD_ALIVE, 3'd3, 32'd7000);
    offer(CMD_ALIVE, 3'd7, 32'd7000);
    offer(CMD_TICK,  3'd1, 32'd6499);       // one past the future margin
    offer(CMD_TICK,  3'd6, 32'd6500);       // exactly at the margin
    offer(CMD_ALIVE, 3'd4, 32'd0);
    offer(CMD_ALIVE, 3'd6, 32'd0);
    offer(CMD_ALIVE, 3'd5, 32'd6000);
    offer(CMD_TICK,  3'd3, 32'd7000);
    offer(CMD_ALIVE, 3'd3, 32'hFFFF_FFFF);
    offer(CMD_ALIVE, 3'd7, 32'hFFFF_FFFF);
    offer(CMD_TICK,  3'd4, 32'hFFFF_FFFF);  // stamp plus timeout needs bit 32
    offer(CMD_TICK,  3'd2, 32'd0);
    offer(CMD_ALIVE, 3'd0, 32'hFFFF_FFFF);
    offer(CMD_TICK,  3'd5, 32'hFFFF_FFFF);
    settle();

    run_phase(0,     7, 0,     0,  0,  1'b0, 170);
    run_phase(65535, 3, 65535, 68, 0,  1'b0, 170);
    run_phase(1000,  $urandom_range(7), 500, 0, 68, 1'b0, 170);
    run_phase($urandom_range(65535), $urandom_range(7), $urandom_range(65535),
              33, 33, 1'b0, 170);
    run_phase(65535, 0, 0,     0,  0,  1'b1, 170);
    run_phase(0,     5, 65535, 33, 33, 1'b0, 170);

    $display("Covered %0d transactions and %0d status results over 7 register settings,",
             items_sent, results_checked);
    $display("with sender gaps, receiver stalls, both, neither, and one long output hold-off.");
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mdhw_pkg.sv
hw/rtl/mdhw_cmp_unit.sv
hw/rtl/multi_device_heartbeat_watchdog.sv
bench/watchdog_checker.sv
bench/tb.sv
